FILE: rtl/lte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_pkg
// Shared types and defaults for the LRU table with expiry.
// ----------------------------------------------------------------------------
package lte_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int KEY_W  = 64;
    localparam int TIME_W = 32;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_CMP  = 2'd1,
        ST_UPD  = 2'd2
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_TOUCH  = 2'd1,
        OP_DROP   = 2'd2,
        OP_INSERT = 2'd3
    } t_op;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        t_op                op;
        logic [KEY_W-1:0]   key;
        logic [TIME_W-1:0]  now;
        logic [TIME_W-1:0]  life;
        logic               expires;
    } t_upd;

    // Priority chain flags handed from one cell to the next.
    typedef struct packed {
        logic found;
        logic free_found;
        logic stale;
    } t_link;

endpackage

FILE: rtl/lte_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_cell
// One table slot: entry storage, local compare and recency rank update.
// ----------------------------------------------------------------------------
module lte_cell #(
    parameter int RANK_W = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_capture,
    input  lte_pkg::t_upd         i_upd,
    input  logic                  i_target,
    input  logic [RANK_W-1:0]     i_ref_rank,
    input  logic [RANK_W-1:0]     i_lru_rank,
    input  lte_pkg::t_link        i_link,
    input  logic [RANK_W-1:0]     i_link_rank,
    output lte_pkg::t_link        o_link,
    output logic [RANK_W-1:0]     o_link_rank,
    output logic                  o_first_hit,
    output logic                  o_first_free,
    output logic                  o_lru
);

    logic                         r_valid;
    logic [lte_pkg::KEY_W-1:0]    r_key;
    logic [lte_pkg::TIME_W-1:0]   r_stamp;
    logic [lte_pkg::TIME_W-1:0]   r_life;
    logic                         r_expires;
    logic [RANK_W-1:0]            r_rank;
    logic                         r_match;
    logic                         r_stale;

    logic [lte_pkg::TIME_W-1:0]   age;

    // Age wraps modulo 2^32.
    assign age = i_upd.now - r_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            unique case (i_upd.op)
                lte_pkg::OP_INSERT: begin
                    if (i_target) begin
                        r_valid <= 1'b1;
                    end
                end
                lte_pkg::OP_DROP: begin
                    if (i_target) begin
                        r_valid <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_match <= r_valid && (r_key == i_upd.key);
            r_stale <= r_expires && (age > r_life);
        end
        unique case (i_upd.op)
            lte_pkg::OP_TOUCH: begin
                if (i_target) begin
                    r_rank <= '0;
                end else if (r_valid && r_rank < i_ref_rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            lte_pkg::OP_DROP: begin
                if (!i_target && r_valid && r_rank > i_ref_rank) begin
                    r_rank <= r_rank - 1'b1;
                end
            end
            lte_pkg::OP_INSERT: begin
                if (i_target) begin
                    r_key     <= i_upd.key;
                    r_stamp   <= i_upd.now;
                    r_life    <= i_upd.life;
                    r_expires <= i_upd.expires;
                    r_rank    <= '0;
                end else if (r_valid) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Lowest matching and lowest free slot win along the chain.
    assign o_first_hit  = r_match && !i_link.found;
    assign o_first_free = !r_valid && !i_link.free_found;
    assign o_lru        = r_valid && (r_rank == i_lru_rank);

    assign o_link.found      = i_link.found | r_match;
    assign o_link.free_found = i_link.free_found | !r_valid;
    assign o_link.stale      = o_first_hit ? r_stale : i_link.stale;
    assign o_link_rank       = o_first_hit ? r_rank : i_link_rank;

endmodule

FILE: rtl/lte_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lte_ctrl
// Command sequencer: latch, compare phase, update decision, result register.
// ----------------------------------------------------------------------------
module lte_ctrl #(
    parameter int ENTRIES = lte_pkg::DEF_ENTRIES,
    parameter int SLOT_W  = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [1:0]                    i_command,
    input  logic [lte_pkg::KEY_W-1:0]     i_key,
    input  logic [lte_pkg::TIME_W-1:0]    i_now_seconds,
    input  logic [lte_pkg::TIME_W-1:0]    i_max_age,
    input  logic                          i_expire_en,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic [ENTRIES-1:0]            i_hit1h,
    input  logic [ENTRIES-1:0]            i_free1h,
    input  logic [ENTRIES-1:0]            i_lru1h,
    input  logic                          i_hit_stale,
    input  logic [SLOT_W-1:0]             i_hit_rank,
    output logic                          o_busy,
    output logic                          o_capture,
    output lte_pkg::t_upd                 o_upd,
    output logic [ENTRIES-1:0]            o_target,
    output logic [SLOT_W-1:0]             o_ref_rank,
    output logic [SLOT_W-1:0]             o_lru_rank,
    output logic                          o_done,
    output logic                          o_hit,
    output logic                          o_stale,
    output logic [SLOT_W-1:0]             o_slot,
    output logic                          o_evicted,
    output logic [SLOT_W-1:0]             o_evicted_slot,
    output logic [CNT_W-1:0]              o_entry_count
);

    lte_pkg::t_state                r_state, n_state;
    lte_pkg::t_cmd                  r_cmd;
    logic [lte_pkg::KEY_W-1:0]      r_key;
    logic [lte_pkg::TIME_W-1:0]     r_now;
    logic [lte_pkg::TIME_W-1:0]     r_life;
    logic                           r_expires;
    logic                           r_enable;
    logic [CNT_W-1:0]               r_count, n_count;

    logic                           r_done;
    logic                           r_hit, n_hit;
    logic                           r_stale, n_stale;
    logic [SLOT_W-1:0]              r_slot, n_slot;
    logic                           r_evicted, n_evicted;
    logic [SLOT_W-1:0]              r_evicted_slot, n_evicted_slot;

    lte_pkg::t_op                   op;
    logic                           accept;
    logic                           any_hit, any_free, full;
    logic [CNT_W-1:0]               count_m1;
    logic [SLOT_W-1:0]              hit_idx, free_idx, lru_idx;

    assign accept   = i_start && !o_busy;
    assign any_hit  = |i_hit1h;
    assign any_free = |i_free1h;
    assign full     = (r_count == CNT_W'(ENTRIES));
    assign count_m1 = r_count - CNT_W'(1);

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_hit1h[i])  hit_idx  = hit_idx  | SLOT_W'(i);
            if (i_free1h[i]) free_idx = free_idx | SLOT_W'(i);
            if (i_lru1h[i])  lru_idx  = lru_idx  | SLOT_W'(i);
        end
    end

    always_comb begin
        n_state        = r_state;
        op             = lte_pkg::OP_NONE;
        o_target       = '0;
        o_ref_rank     = i_hit_rank;
        n_count        = r_count;
        n_hit          = 1'b0;
        n_stale        = 1'b0;
        n_slot         = '0;
        n_evicted      = 1'b0;
        n_evicted_slot = '0;
        unique case (r_state)
            lte_pkg::ST_IDLE: begin
                if (accept) n_state = lte_pkg::ST_CMP;
            end
            lte_pkg::ST_CMP: begin
                n_state = lte_pkg::ST_UPD;
            end
            lte_pkg::ST_UPD: begin
                n_state = accept ? lte_pkg::ST_CMP : lte_pkg::ST_IDLE;
                unique case (r_cmd)
                    lte_pkg::CMD_LOOKUP: begin
                        if (r_enable && any_hit) begin
                            op       = lte_pkg::OP_TOUCH;
                            o_target = i_hit1h;
                            n_hit    = 1'b1;
                            n_stale  = i_hit_stale;
                            n_slot   = hit_idx;
                        end else if (r_enable && full) begin
                            op             = lte_pkg::OP_DROP;
                            o_target       = i_lru1h;
                            o_ref_rank     = o_lru_rank;
                            n_count        = count_m1;
                            n_evicted      = 1'b1;
                            n_evicted_slot = lru_idx;
                        end
                    end
                    lte_pkg::CMD_INSERT: begin
                        op = lte_pkg::OP_INSERT;
                        if (any_free) begin
                            o_target = i_free1h;
                            n_slot   = free_idx;
                            n_count  = r_count + CNT_W'(1);
                        end else begin
                            // Evict and refill the same slot: count holds.
                            o_target       = i_lru1h;
                            n_slot         = lru_idx;
                            n_evicted      = 1'b1;
                            n_evicted_slot = lru_idx;
                        end
                    end
                    lte_pkg::CMD_REMOVE: begin
                        if (any_hit) begin
                            op       = lte_pkg::OP_DROP;
                            o_target = i_hit1h;
                            n_hit    = 1'b1;
                            n_stale  = i_hit_stale;
                            n_slot   = hit_idx;
                            n_count  = count_m1;
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = lte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lte_pkg::ST_IDLE;
            r_count  <= '0;
            r_enable <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= (r_state == lte_pkg::ST_UPD);
            if (i_cfg_we) r_enable <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= lte_pkg::t_cmd'(i_command);
            r_key     <= i_key;
            r_now     <= i_now_seconds;
            r_life    <= i_max_age;
            r_expires <= i_expire_en;
        end
        if (r_state == lte_pkg::ST_UPD) begin
            r_hit          <= n_hit;
            r_stale        <= n_stale;
            r_slot         <= n_slot;
            r_evicted      <= n_evicted;
            r_evicted_slot <= n_evicted_slot;
        end
    end

    assign o_busy         = (r_state == lte_pkg::ST_CMP) || !i_rst_n;
    assign o_capture      = (r_state == lte_pkg::ST_CMP);
    assign o_lru_rank     = count_m1[SLOT_W-1:0];
    assign o_upd.op       = op;
    assign o_upd.key      = r_key;
    assign o_upd.now      = r_now;
    assign o_upd.life     = r_life;
    assign o_upd.expires  = r_expires;

    assign o_done         = r_done;
    assign o_hit          = r_hit;
    assign o_stale        = r_stale;
    assign o_slot         = r_slot;
    assign o_evicted      = r_evicted;
    assign o_evicted_slot = r_evicted_slot;
    assign o_entry_count  = r_count;

    // Count never exceeds the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count above table size");

    // Count moves only on the update cycle.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != lte_pkg::ST_UPD) |=> $stable(r_count))
        else $error("entry count changed outside update");

    // Full table: ranks are a permutation, so exactly one slot is oldest.
    a_lru_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lte_pkg::ST_UPD && full) |-> $onehot(i_lru1h))
        else $error("full table without a single LRU slot");

    // Any state change hits exactly one slot.
    a_target_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (op != lte_pkg::OP_NONE) |-> $onehot(o_target))
        else $error("update without a single target slot");

    // A result strobe follows the update cycle and lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == lte_pkg::ST_UPD))
        else $error("result strobe without update");

endmodule

FILE: rtl/lru_table_with_expiry_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_table_with_expiry_top
// Fully associative LRU table with per-entry expiry, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage: raise i_start with a command (lookup, insert, remove) while o_busy is
// low; the transaction is taken at that edge. Every command returns exactly one
// result as a single-cycle o_done pulse with the result fields; the receiver
// cannot stall, so sample o_done every cycle. A command passes through a compare
// state in which every cell matches its key and judges staleness, then an update
// state in which the priority chain across the cells picks the slot and the
// recency ranks move. A new command is accepted during the update state, so
// the next command is taken while the last one finishes its update. Write
// i_cfg_wdata with i_cfg_we to set cache_enable; do so only while no command
// is outstanding. o_busy is held high during reset.
// ----------------------------------------------------------------------------
module lru_table_with_expiry_top #(
    parameter int ENTRIES = lte_pkg::DEF_ENTRIES,
    parameter int SLOT_W  = $clog2(ENTRIES),
    parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [1:0]                    i_command,
    input  logic [lte_pkg::KEY_W-1:0]     i_key,
    input  logic [lte_pkg::TIME_W-1:0]    i_now_seconds,
    input  logic [lte_pkg::TIME_W-1:0]    i_max_age,
    input  logic                          i_expire_en,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    output logic                          o_done,
    output logic                          o_hit,
    output logic                          o_stale,
    output logic [SLOT_W-1:0]             o_slot,
    output logic                          o_evicted,
    output logic [SLOT_W-1:0]             o_evicted_slot,
    output logic [CNT_W-1:0]              o_entry_count
);

    // Controller broadcast to the row.
    logic                  capture;
    lte_pkg::t_upd         upd;
    logic [ENTRIES-1:0]    target;
    logic [SLOT_W-1:0]     ref_rank;
    logic [SLOT_W-1:0]     lru_rank;

    // Per-cell selections gathered back.
    logic [ENTRIES-1:0]    hit1h;
    logic [ENTRIES-1:0]    free1h;
    logic [ENTRIES-1:0]    lru1h;

    // Chain between neighbors; element 0 feeds the first cell.
    lte_pkg::t_link        link      [ENTRIES+1];
    logic [SLOT_W-1:0]     link_rank [ENTRIES+1];

    assign link[0]      = '0;
    assign link_rank[0] = '0;

    lte_ctrl #(
        .ENTRIES (ENTRIES),
        .SLOT_W  (SLOT_W),
        .CNT_W   (CNT_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_now_seconds  (i_now_seconds),
        .i_max_age      (i_max_age),
        .i_expire_en    (i_expire_en),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_hit1h        (hit1h),
        .i_free1h       (free1h),
        .i_lru1h        (lru1h),
        .i_hit_stale    (link[ENTRIES].stale),
        .i_hit_rank     (link_rank[ENTRIES]),
        .o_busy         (o_busy),
        .o_capture      (capture),
        .o_upd          (upd),
        .o_target       (target),
        .o_ref_rank     (ref_rank),
        .o_lru_rank     (lru_rank),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_stale        (o_stale),
        .o_slot         (o_slot),
        .o_evicted      (o_evicted),
        .o_evicted_slot (o_evicted_slot),
        .o_entry_count  (o_entry_count)
    );

    // One cell per slot; slot 0 sits at the head of the chain so the lowest
    // matching or free slot wins.
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lte_cell #(
            .RANK_W (SLOT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_capture    (capture),
            .i_upd        (upd),
            .i_target     (target[g]),
            .i_ref_rank   (ref_rank),
            .i_lru_rank   (lru_rank),
            .i_link       (link[g]),
            .i_link_rank  (link_rank[g]),
            .o_link       (link[g+1]),
            .o_link_rank  (link_rank[g+1]),
            .o_first_hit  (hit1h[g]),
            .o_first_free (free1h[g]),
            .o_lru        (lru1h[g])
        );
    end

endmodule

FILE: dv/tb_lru_table_with_expiry_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_table_with_expiry_top
// Self-checking bench for the LRU table with expiry: a burst-driven command
// driver feeds lookups, inserts and removes, a transaction-level table predictor
// works out each response, and a monitor checks every o_done transaction.
// ----------------------------------------------------------------------------
module tb_lru_table_with_expiry_top;

    import lte_pkg::*;

    localparam int ENTRIES     = lte_pkg::DEF_ENTRIES;
    localparam int SLOT_W      = $clog2(ENTRIES);
    localparam int CNT_W       = $clog2(ENTRIES + 1);
    localparam int POOL_KEYS   = 20;
    localparam int CYCLE_LIMIT = 300000;

    // One command as presented on the input ports.
    typedef struct {
        t_cmd              cmd;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] max_age;
        logic              expire_en;
    } t_table_cmd;

    // One response as seen on the result ports.
    typedef struct packed {
        logic              hit;
        logic              stale;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [SLOT_W-1:0] evicted_slot;
        logic [CNT_W-1:0]  entry_count;
    } t_table_resp;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_start       = 1'b0;
    logic [1:0]          i_command     = CMD_LOOKUP;
    logic [KEY_W-1:0]    i_key         = '0;
    logic [TIME_W-1:0]   i_now_seconds = '0;
    logic [TIME_W-1:0]   i_max_age     = '0;
    logic                i_expire_en   = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic                i_cfg_wdata   = 1'b0;
    logic                o_busy;
    logic                o_done;
    logic                o_hit;
    logic                o_stale;
    logic [SLOT_W-1:0]   o_slot;
    logic                o_evicted;
    logic [SLOT_W-1:0]   o_evicted_slot;
    logic [CNT_W-1:0]    o_entry_count;

    lru_table_with_expiry_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_now_seconds  (i_now_seconds),
        .i_max_age      (i_max_age),
        .i_expire_en    (i_expire_en),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_hit          (o_hit),
        .o_stale        (o_stale),
        .o_slot         (o_slot),
        .o_evicted      (o_evicted),
        .o_evicted_slot (o_evicted_slot),
        .o_entry_count  (o_entry_count)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_table_cmd  cmd_backlog[$];     // commands not yet handed to the DUT
    t_table_resp resp_expected[$];   // predicted responses, oldest first
    t_table_cmd  cur_cmd;            // command currently on the ports
    int          burst_left  = 1;
    int          gap_left    = 0;
    int          fail_count  = 0;
    int          cycle_count = 0;

    // Shadow copy of the table, updated when a transaction is accepted.
    bit                tbl_valid   [ENTRIES];
    logic [KEY_W-1:0]  tbl_key     [ENTRIES];
    logic [TIME_W-1:0] tbl_stamp   [ENTRIES];
    logic [TIME_W-1:0] tbl_life    [ENTRIES];
    bit                tbl_expires [ENTRIES];
    int                tbl_rank    [ENTRIES];   // 0 is most recent
    int                live_count  = 0;
    bit                cache_on    = 1'b0;

    // Random stimulus state.
    logic [KEY_W-1:0]  key_pool [POOL_KEYS];
    logic [TIME_W-1:0] sim_now = '0;

    // ------------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------------
    function automatic int lowest_match(logic [KEY_W-1:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    // Age wraps modulo 2^32, so a clock that steps back reads as very old.
    function automatic bit has_expired(int s, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        age = now - tbl_stamp[s];
        return tbl_expires[s] && (age > tbl_life[s]);
    endfunction

    function automatic void promote(int s);
        int r;
        r = tbl_rank[s];
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && i != s && tbl_rank[i] < r)
                tbl_rank[i]++;
        tbl_rank[s] = 0;
    endfunction

    function automatic void release_slot(int s);
        int r;
        r = tbl_rank[s];
        tbl_valid[s] = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_rank[i] > r)
                tbl_rank[i]--;
        if (live_count > 0)
            live_count--;
    endfunction

    function automatic int drop_oldest();
        int lru;
        lru = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && (lru < 0 || tbl_rank[i] > tbl_rank[lru]))
                lru = i;
        if (lru >= 0)
            release_slot(lru);
        return lru;
    endfunction

    // Apply one command to the shadow table and return the response it causes.
    function automatic t_table_resp run_command(t_table_cmd c);
        t_table_resp r;
        int s;
        r = '0;
        case (c.cmd)
            CMD_LOOKUP: begin
                if (cache_on) begin
                    s = lowest_match(c.key);
                    if (s >= 0) begin
                        r.hit   = 1'b1;
                        r.stale = has_expired(s, c.now);
                        r.slot  = SLOT_W'(s);
                        promote(s);
                    end else if (live_count >= ENTRIES) begin
                        s = drop_oldest();
                        if (s >= 0) begin
                            r.evicted      = 1'b1;
                            r.evicted_slot = SLOT_W'(s);
                        end
                    end
                end
            end
            CMD_INSERT: begin
                s = -1;
                for (int i = ENTRIES - 1; i >= 0; i--)
                    if (!tbl_valid[i])
                        s = i;
                if (s < 0) begin
                    s = drop_oldest();
                    r.evicted      = 1'b1;
                    r.evicted_slot = SLOT_W'(s);
                end
                for (int i = 0; i < ENTRIES; i++)
                    if (tbl_valid[i])
                        tbl_rank[i]++;
                tbl_valid[s]   = 1'b1;
                tbl_key[s]     = c.key;
                tbl_stamp[s]   = c.now;
                tbl_life[s]    = c.max_age;
                tbl_expires[s] = c.expire_en;
                tbl_rank[s]    = 0;
                live_count++;
                r.slot = SLOT_W'(s);
            end
            CMD_REMOVE: begin
                s = lowest_match(c.key);
                if (s >= 0) begin
                    r.hit   = 1'b1;
                    r.stale = has_expired(s, c.now);
                    r.slot  = SLOT_W'(s);
                    release_slot(s);
                end
            end
            default: ;
        endcase
        r.entry_count = CNT_W'(live_count);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Abort a hung run; the limit covers every command waiting out the
    // longest sender gap several times over.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: present commands in bursts with random gaps. A transaction
    // moves at an edge with start high and busy low; predict it right there.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                resp_expected.push_back(run_command(cur_cmd));
            end
            if (i_start && o_busy) begin
                // Hold the command until the block takes it.
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                cur_cmd        = cmd_backlog.pop_front();
                i_start       <= 1'b1;
                i_command     <= cur_cmd.cmd;
                i_key         <= cur_cmd.key;
                i_now_seconds <= cur_cmd.now;
                i_max_age     <= cur_cmd.max_age;
                i_expire_en   <= cur_cmd.expire_en;
                if (burst_left <= 1) begin
                    // Mostly short bursts, now and then a long back-to-back run.
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: every o_done pulse is one response transaction; check it
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    task automatic check_field(string name, logic [KEY_W-1:0] exp, logic [KEY_W-1:0] act);
        if (exp !== act) begin
            $error("%s: expected %0h, actual %0h", name, exp, act);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_resp want;
        if (i_rst_n && o_done) begin
            if (resp_expected.size() == 0) begin
                $error("response transaction with no command outstanding");
                fail_count++;
            end else begin
                want = resp_expected.pop_front();
                check_field("hit",          KEY_W'(want.hit),          KEY_W'(o_hit));
                check_field("stale",        KEY_W'(want.stale),        KEY_W'(o_stale));
                check_field("slot",         KEY_W'(want.slot),         KEY_W'(o_slot));
                check_field("evicted",      KEY_W'(want.evicted),      KEY_W'(o_evicted));
                check_field("evicted_slot", KEY_W'(want.evicted_slot),
                            KEY_W'(o_evicted_slot));
                check_field("entry_count",  KEY_W'(want.entry_count),
                            KEY_W'(o_entry_count));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_cmd(t_cmd c, logic [KEY_W-1:0] k, logic [TIME_W-1:0] now,
                           logic [TIME_W-1:0] age, logic has);
        t_table_cmd item;
        item.cmd       = c;
        item.key       = k;
        item.now       = now;
        item.max_age   = age;
        item.expire_en = has;
        cmd_backlog.push_back(item);
    endtask

    // Keys come mostly from a pool a bit larger than the table, so hits,
    // duplicates, removes and full-table evictions all happen often.
    task automatic add_random_cmds(int n);
        int                pick;
        t_cmd              c;
        logic [KEY_W-1:0]  k;
        logic [TIME_W-1:0] age;
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            c = (pick < 45) ? CMD_LOOKUP :
                (pick < 80) ? CMD_INSERT :
                (pick < 95) ? CMD_REMOVE : CMD_NONE;
            // Advance the clock slowly; sometimes step it back or jump anywhere.
            pick = $urandom_range(0, 99);
            if (pick < 88)
                sim_now = sim_now + $urandom_range(0, 6);
            else if (pick < 94)
                sim_now = sim_now - $urandom_range(1, 20);
            else
                sim_now = $urandom;
            pick = $urandom_range(0, 99);
            if (pick < 80)
                age = $urandom_range(0, 24);
            else if (pick < 90)
                age = '0;
            else
                age = $urandom;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, POOL_KEYS - 1)];
            else
                k = {$urandom, $urandom};
            add_cmd(c, k, sim_now, age, 1'($urandom_range(0, 1)));
        end
    endtask

    // Wait until every command is taken and every response is back. Sample
    // one step past the edge so the driver and monitor have settled.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (cmd_backlog.size() != 0 || i_start || resp_expected.size() != 0
                   || o_busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cache_enable(bit v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cache_on     = v;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] key_c;
        logic [KEY_W-1:0] key_d;
        for (int i = 0; i < POOL_KEYS; i++)
            key_pool[i] = {$urandom, $urandom};
        key_a = key_pool[0];
        key_b = key_pool[1];
        key_c = key_pool[2];
        key_d = key_pool[3];
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = 0;
        end

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        wait_idle();

        // Disabled cache: insert and remove still act, lookups change nothing.
        write_cache_enable(1'b0);
        add_cmd(CMD_INSERT, key_a, 32'd1000, 32'd50, 1'b1);
        add_cmd(CMD_LOOKUP, key_a, 32'd1001, 32'd0,  1'b0);
        add_cmd(CMD_REMOVE, key_b, 32'd1002, 32'd0,  1'b0);
        wait_idle();

        write_cache_enable(1'b1);
        // Fresh hit, then the same entry past its lifetime, then a plain miss.
        add_cmd(CMD_LOOKUP, key_a, 32'd1010, 32'd0, 1'b0);
        add_cmd(CMD_LOOKUP, key_a, 32'd1051, 32'd0, 1'b0);
        add_cmd(CMD_LOOKUP, key_c, 32'd1052, 32'd0, 1'b0);
        // Field extremes: all-ones and all-zero keys, times and lifetimes.
        add_cmd(CMD_INSERT, '1, '1, '1, 1'b1);
        add_cmd(CMD_INSERT, '0, '1, '0, 1'b1);
        add_cmd(CMD_LOOKUP, '0, '1, '0, 1'b0);
        // Clock wraps to zero: age one against a zero lifetime reads stale.
        add_cmd(CMD_LOOKUP, '0, '0, '0, 1'b0);
        // Age of all ones does not exceed a lifetime of all ones.
        add_cmd(CMD_LOOKUP, '1, 32'hFFFF_FFFE, '0, 1'b0);
        // Clock running backwards makes an expiring entry stale.
        add_cmd(CMD_INSERT, key_b, 32'd500, 32'd10, 1'b1);
        add_cmd(CMD_LOOKUP, key_b, 32'd400, 32'd0,  1'b0);
        // Entry without a lifetime never goes stale.
        add_cmd(CMD_INSERT, key_d, '0, '0, 1'b0);
        add_cmd(CMD_LOOKUP, key_d, '1, '0, 1'b0);
        // Duplicate key: lookup and remove take the lowest slot first;
        // the first remove also reports the removed copy as stale.
        add_cmd(CMD_INSERT, key_a, 32'd2000, 32'd5, 1'b1);
        add_cmd(CMD_LOOKUP, key_a, 32'd2000, 32'd0, 1'b0);
        add_cmd(CMD_REMOVE, key_a, 32'd2000, 32'd0, 1'b0);
        add_cmd(CMD_LOOKUP, key_a, 32'd2001, 32'd0, 1'b0);
        add_cmd(CMD_REMOVE, key_a, 32'd2001, 32'd0, 1'b0);
        add_cmd(CMD_REMOVE, key_a, 32'd2002, 32'd0, 1'b0);
        // Unknown command with every field high: nothing changes.
        add_cmd(CMD_NONE, '1, '1, '1, 1'b1);
        add_cmd(CMD_INSERT, key_c, 32'd7, 32'd3, 1'b0);
        wait_idle();

        // Random traffic across enable settings.
        sim_now = 32'd3000;
        add_random_cmds(900);
        wait_idle();

        write_cache_enable(1'b0);
        add_random_cmds(160);
        wait_idle();

        write_cache_enable(1'b1);
        add_random_cmds(470);
        wait_idle();

        repeat (6) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
